>>> hw/rtl/rbg_pkg.sv
// rbg_pkg: shared constants and types for the renko brick generator
// no dependencies; used by rbg_alu and renko_brick_generator
package rbg_pkg;

	localparam int unsigned PRICE_W          = 32;
	localparam int unsigned TIME_W           = 48;
	localparam int unsigned SIZE_W           = 31;
	localparam int unsigned MAX_BRICKS       = 64;
	localparam int unsigned CNT_W            = $clog2(MAX_BRICKS + 1);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(100);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIST,
		ST_NEG,
		ST_BRICK
	} rbg_state_t;

	// result of the shared subtract/compare unit
	typedef struct packed {
		logic [PRICE_W-1:0] diff;
		logic               borrow;
		logic               lt2;
	} rbg_alu_res_t;

endpackage

>>> hw/rtl/rbg_alu.sv
// rbg_alu: shared subtract and compare unit of the brick sequencer
// depends on rbg_pkg
module rbg_alu (
	input  logic [rbg_pkg::PRICE_W-1:0] op_a,
	input  logic [rbg_pkg::PRICE_W-1:0] op_b,
	output rbg_pkg::rbg_alu_res_t       res
);

	logic [rbg_pkg::PRICE_W:0] sub;

	always_comb begin
		sub        = {1'b0, op_a} - {1'b0, op_b};
		res.diff   = sub[rbg_pkg::PRICE_W-1:0];
		res.borrow = sub[rbg_pkg::PRICE_W];
		// a < 2*b, so the brick about to go out is the final one
		res.lt2    = {1'b0, op_a} < {op_b, 1'b0};
	end

endmodule

>>> hw/rtl/renko_brick_generator.sv
// renko_brick_generator: top level, sequencer, anchor state and output register
// depends on rbg_pkg and rbg_alu
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | close_price, candle_time
//  out      | out_valid / out_stall| brick_open, brick_close, brick_up,
//           |                      | brick_time, last_brick
//  cfg      | cfg_valid / cfg_ready| brick_size
//
// every item is taken in idle; with the anchor clear that is all; otherwise
// the distance is formed in ST_DIST (and ST_NEG on a rising move), then one
// brick per cycle while the output is free, via the shared subtract/compare
// unit, or back to idle when no brick is due; up to 64 bricks per item
// a stalled output freezes the brick loop; in_stall is high until the loop ends
// cfg_ready only in idle and only while no input beat is offered
// reset: brick size 100, anchor clear, output empty
module renko_brick_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rbg_pkg::PRICE_W-1:0]        close_price,
	input  logic [rbg_pkg::TIME_W-1:0]         candle_time,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rbg_pkg::PRICE_W-1:0]        brick_open,
	output logic [rbg_pkg::PRICE_W-1:0]        brick_close,
	output logic                               brick_up,
	output logic [rbg_pkg::TIME_W-1:0]         brick_time,
	output logic                               last_brick,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rbg_pkg::SIZE_W-1:0]         brick_size
);

	rbg_pkg::rbg_state_t          state_q, state_d;
	logic [rbg_pkg::SIZE_W-1:0]   size_q;
	logic [rbg_pkg::PRICE_W-1:0]  anchor_q;
	logic                         anchor_valid_q;
	logic [rbg_pkg::PRICE_W-1:0]  price_q;
	logic [rbg_pkg::TIME_W-1:0]   time_q;
	logic [rbg_pkg::PRICE_W-1:0]  dist_q;
	logic                         up_q;
	logic [rbg_pkg::CNT_W-1:0]    cnt_q;
	logic                         out_valid_q;
	logic [rbg_pkg::PRICE_W-1:0]  open_q;
	logic [rbg_pkg::PRICE_W-1:0]  close_q;
	logic                         up_out_q;
	logic [rbg_pkg::TIME_W-1:0]   time_out_q;
	logic                         last_q;

	logic [rbg_pkg::PRICE_W-1:0]  op_a, op_b;
	rbg_pkg::rbg_alu_res_t        alu;
	logic [rbg_pkg::PRICE_W-1:0]  size_ext;
	logic [rbg_pkg::PRICE_W-1:0]  next_anchor;
	logic                         in_acc, cfg_acc, slot_free;
	logic                         load_dist, load_neg, emit, emit_last;

	assign size_ext    = {1'b0, size_q};
	assign next_anchor = up_q ? anchor_q + size_ext : anchor_q - size_ext;
	assign in_acc      = in_valid && !in_stall;
	assign cfg_acc     = cfg_valid && cfg_ready;
	assign slot_free   = !out_valid_q || !out_stall;

	rbg_alu u_alu (
		.op_a (op_a),
		.op_b (op_b),
		.res  (alu)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		op_a      = anchor_q;
		op_b      = price_q;
		load_dist = 1'b0;
		load_neg  = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			rbg_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				// an input beat goes first
				cfg_ready = !in_valid;
				if (in_valid && anchor_valid_q) begin
					state_d = rbg_pkg::ST_DIST;
				end
			end
			rbg_pkg::ST_DIST: begin
				// anchor - price; a borrow means the move is upward
				if (alu.borrow) begin
					state_d = rbg_pkg::ST_NEG;
				end else begin
					load_dist = 1'b1;
					state_d   = rbg_pkg::ST_BRICK;
				end
			end
			rbg_pkg::ST_NEG: begin
				op_a     = price_q;
				op_b     = anchor_q;
				load_neg = 1'b1;
				state_d  = rbg_pkg::ST_BRICK;
			end
			rbg_pkg::ST_BRICK: begin
				op_a = dist_q;
				op_b = size_ext;
				if (alu.borrow) begin
					state_d = rbg_pkg::ST_IDLE;
				end else if (slot_free) begin
					emit      = 1'b1;
					emit_last = alu.lt2 ||
						(cnt_q == rbg_pkg::CNT_W'(rbg_pkg::MAX_BRICKS - 1));
					if (emit_last) begin
						state_d = rbg_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = rbg_pkg::ST_IDLE;
			end
		endcase
	end

	// control state: size register, anchor flag and anchor, brick count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q         <= rbg_pkg::SIZE_RESET;
			anchor_valid_q <= 1'b0;
			out_valid_q    <= 1'b0;
			anchor_q       <= '0;
			cnt_q          <= '0;
		end else begin
			if (cfg_acc && brick_size != '0) begin
				size_q         <= brick_size;
				anchor_valid_q <= 1'b0;
			end else if (in_acc && !anchor_valid_q) begin
				anchor_valid_q <= 1'b1;
			end
			if (in_acc && !anchor_valid_q) begin
				anchor_q <= close_price;
			end else if (emit) begin
				anchor_q <= next_anchor;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			price_q <= close_price;
			time_q  <= candle_time;
		end
		if (load_dist) begin
			dist_q <= alu.diff;
			up_q   <= 1'b0;
		end else if (load_neg) begin
			dist_q <= alu.diff;
			up_q   <= 1'b1;
		end else if (emit) begin
			dist_q <= alu.diff;
		end
		if (emit) begin
			open_q     <= anchor_q;
			close_q    <= next_anchor;
			up_out_q   <= up_q;
			time_out_q <= time_q;
			last_q     <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign brick_open  = open_q;
	assign brick_close = close_q;
	assign brick_up    = up_out_q;
	assign brick_time  = time_out_q;
	assign last_brick  = last_q;

	a_anchor_follows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> anchor_q == brick_close)
		else $error("anchor does not follow emitted brick");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rbg_pkg::CNT_W'(rbg_pkg::MAX_BRICKS))
		else $error("brick count above limit");

	a_brick_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((up_out_q ? close_q - open_q : open_q - close_q) == size_ext))
		else $error("brick width differs from brick size");

	a_no_brick_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbg_pkg::ST_BRICK && alu.borrow) |=> state_q == rbg_pkg::ST_IDLE)
		else $error("sequencer did not finish on short distance");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == rbg_pkg::ST_IDLE && last_q))
		else $error("final brick did not end the item");

endmodule
